// File: design/hktbl_pkg.sv
// ----------------------------------------------------------------------------
// hktbl_pkg
// Shared constants and types for the hashed key table.
// ----------------------------------------------------------------------------
package hktbl_pkg;

  localparam int Buckets       = 256;
  localparam int OverflowNodes = 256;
  localparam int SlotsPerNode  = 3;
  localparam int TotalNodes    = Buckets + OverflowNodes;
  localparam int NodeW         = $clog2(TotalNodes);
  localparam int PoolW         = $clog2(OverflowNodes + 1);
  localparam int CountW        = 11;
  localparam int BcW           = 9;

  localparam logic [63:0] HashSeed = 64'd5381;
  localparam int HashShift = 11;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // one node row: three keys, three values, link, full flag
  typedef struct packed {
    logic [2:0][63:0] keys;
    logic [2:0][31:0] vals;
    logic [NodeW-1:0] link;
    logic             full;
  } node_t;

  typedef struct packed {
    logic        status;
    logic        found;
    logic [31:0] value_out;
    logic [CountW-1:0] entry_count;
  } result_t;

endpackage

// File: design/hashed_key_chained_table.sv
// ----------------------------------------------------------------------------
// hashed_key_chained_table
// Byte-streamed key hashing into a chained three-slot bucket table.
// ----------------------------------------------------------------------------
// Sequence: a non-last byte only updates the hash. A last byte with a zero hash or
// op 3 goes straight to the emit state; otherwise a bit-serial division takes the
// 64-bit hash mod bucket_count (clamped to 1..256), then each node visited passes
// READ and EVAL (a set that misses walks the chain again from home), then emit.
// Throughput: one item at a time; input waits while an operation runs or a
// result is held. Reset: rst (synchronous) clears control; a clearing pass then
// zeroes every node row, during which no item is accepted.
module hashed_key_chained_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // op[1:0], key_byte[9:2], value_in[41:10], zero pad
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // status[0], found[1], value_out[33:2],
                                 // entry_count[44:34], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // bucket_count[8:0]
);
  import hktbl_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_EVAL  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]        state;
  logic [63:0]       hacc;
  logic [63:0]       hkey;
  logic [1:0]        op;
  logic [31:0]       vin;
  logic [BcW-1:0]    bucket_count;
  logic [BcW-1:0]    divisor;
  logic [BcW:0]      rem;
  logic [5:0]        bit_idx;
  logic [NodeW-1:0]  node;
  logic [NodeW-1:0]  clr_addr;
  logic [PoolW-1:0]  pool_used;
  logic [CountW-1:0] occ;
  logic              set_miss;   // set walk: key absent, now inserting
  logic [9:0]        steps;
  result_t           res;

  // node memory
  node_t             mem [TotalNodes];
  node_t             rd;
  logic              wr_en;
  logic [NodeW-1:0]  wr_addr;
  node_t             wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd <= mem[node];
  end

  // input / config decode
  logic [7:0]  kb;
  logic [63:0] hnew;
  assign kb   = s_tdata[9:2];
  assign hnew = hacc + (hacc << HashShift) + {{56{kb[7]}}, kb};

  assign s_tready  = (state == ST_IDLE) && !m_tvalid;
  assign cfg_ready = 1'b1;

  always_comb begin
    divisor = bucket_count;
    if (bucket_count == '0) divisor = BcW'(1);
    else if (bucket_count > BcW'(Buckets)) divisor = BcW'(Buckets);
  end

  // evaluate a read node row
  logic [2:0] hit, empty;
  logic [1:0] hit_i, emp_i;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hit[i]   = rd.keys[i] == hkey;
      empty[i] = rd.keys[i] == 64'd0;
    end
    hit_i = hit[0] ? 2'd0 : (hit[1] ? 2'd1 : 2'd2);
    emp_i = empty[0] ? 2'd0 : (empty[1] ? 2'd1 : 2'd2);
  end

  logic link_ok;
  assign link_ok = rd.link != '0;

  // write port: clearing pass or table update
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = node;
    wr_data = rd;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (state == ST_EVAL) begin
      if (!set_miss && (|hit)) begin
        if (op == OP_SET) begin
          wr_en = 1'b1;
          wr_data.vals[hit_i] = vin;
        end else if (op == OP_REMOVE) begin
          wr_en = 1'b1;
          wr_data.keys[hit_i] = '0;
          wr_data.full = 1'b0;
        end
      end else if (set_miss) begin
        if (!rd.full) begin
          wr_en = 1'b1;
          wr_data.keys[emp_i] = hkey;
          wr_data.vals[emp_i] = vin;
          wr_data.full = (empty & ~(3'b1 << emp_i)) == 3'b000;
        end else if (!link_ok && pool_used < PoolW'(OverflowNodes)) begin
          wr_en = 1'b1;
          wr_data.link = NodeW'(Buckets) + NodeW'(pool_used);
        end
      end
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      hacc         <= HashSeed;
      bucket_count <= BcW'(256);
      pool_used    <= '0;
      occ          <= '0;
      m_tvalid     <= 1'b0;
      set_miss     <= 1'b0;
    end else begin
      if (cfg_valid) bucket_count <= cfg_data[BcW-1:0];
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == NodeW'(TotalNodes - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            if (!s_tlast) begin
              hacc <= hnew;
            end else begin
              hacc    <= HashSeed;
              hkey    <= hnew;
              op      <= s_tdata[1:0];
              vin     <= s_tdata[41:10];
              rem     <= '0;
              bit_idx <= 6'd63;
              res     <= '0;
              set_miss <= 1'b0;
              steps   <= '0;
              if (hnew == 64'd0 || s_tdata[1:0] == OP_NONE) state <= ST_OUT;
              else state <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          // restoring division, one bit per cycle
          if ({rem[BcW-1:0], hkey[bit_idx]} >= {1'b0, divisor}) begin
            rem <= {rem[BcW-1:0], hkey[bit_idx]} - {1'b0, divisor};
          end else begin
            rem <= {rem[BcW-1:0], hkey[bit_idx]};
          end
          bit_idx <= bit_idx - 1'b1;
          if (bit_idx == 6'd0) state <= ST_READ;
          if (bit_idx == 6'd0) begin
            if ({rem[BcW-1:0], hkey[0]} >= {1'b0, divisor})
              node <= NodeW'({rem[BcW-1:0], hkey[0]} - {1'b0, divisor});
            else
              node <= NodeW'({rem[BcW-1:0], hkey[0]});
          end
        end
        ST_READ: state <= ST_EVAL;
        ST_EVAL: begin
          steps <= steps + 1'b1;
          state <= ST_OUT;
          if (!set_miss) begin
            if (|hit) begin
              res.found <= 1'b1;
              if (op != OP_SET) res.value_out <= rd.vals[hit_i];
              if (op == OP_REMOVE && occ != '0) occ <= occ - 1'b1;
            end else if (link_ok) begin
              node  <= rd.link;
              state <= ST_READ;
            end else if (op == OP_SET) begin
              // restart from the home node to insert
              set_miss <= 1'b1;
              node  <= NodeW'(rem);
              state <= ST_READ;
            end
          end else begin
            if (!rd.full) begin
              occ <= occ + 1'b1;
            end else if (link_ok) begin
              node  <= rd.link;
              state <= ST_READ;
            end else if (pool_used < PoolW'(OverflowNodes)) begin
              node      <= NodeW'(Buckets) + NodeW'(pool_used);
              pool_used <= pool_used + 1'b1;
              state     <= ST_READ;
            end else begin
              res.status <= 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'd0, occ, res.value_out, res.found, res.status};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_no_out_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !m_tvalid) else $error("output during clear");
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    pool_used <= PoolW'(OverflowNodes)) else $error("pool overrun");
  a_insert_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && set_miss && !rd.full) |-> (|empty))
    else $error("non-full node without empty slot");
endmodule
